/* src/ndf_pkg.sv */
// Shared types and constants for the netstring deframer.
package ndf_pkg;

    // Header byte that reaches this count is ill formed.
    localparam int MAX_HEADER_BYTES = 21;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int CAP_W     = 32;
    localparam int CAP_RESET = 4096;
    localparam int LEN_W     = 32;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_ILL     = 3'd3,
        KIND_BIG     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        payload_byte;
        logic              payload_last;
        logic [LEN_W-1:0]  frame_length;
    } result_t;

endpackage

/* src/ndf_parse.sv */
// Netstring parse state and per-byte decode.
module ndf_parse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [7:0]                  rx_byte,
    input  logic [ndf_pkg::CAP_W-1:0]   capacity,
    output ndf_pkg::result_t            result
);
    import ndf_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   acc_reg, acc_next;
    logic               over_reg, over_next;   // length exceeded 32 bits
    logic [LEN_W-1:0]   rem_reg, rem_next;

    logic [CNT_W-1:0]   cnt_inc;
    logic               is_digit;
    logic [LEN_W+3:0]   acc_mac;

    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    // acc*10 + digit as two shifted adds
    assign acc_mac  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {(LEN_W-4)'(0), 8'(rx_byte - CHAR_ZERO)};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        over_next  = over_reg;
        rem_next   = rem_reg;
        result     = '{kind: KIND_HEADER, payload_byte: 8'd0,
                       payload_last: 1'b0, frame_length: '0};
        unique case (phase_reg)
            PH_PAYLOAD: begin
                result.kind         = KIND_PAYLOAD;
                result.payload_byte = rx_byte;
                if (rem_reg <= LEN_W'(1)) begin
                    result.payload_last = 1'b1;
                    rem_next            = '0;
                    phase_next          = PH_TRAILER;
                end else begin
                    rem_next = rem_reg - LEN_W'(1);
                end
            end
            PH_TRAILER: begin
                if (rx_byte == CHAR_COMMA) begin
                    result.kind         = KIND_DONE;
                    result.frame_length = acc_reg;
                end else begin
                    result.kind = KIND_ILL;
                end
                phase_next = PH_HEADER;
                cnt_next   = '0;
                acc_next   = '0;
                over_next  = 1'b0;
                rem_next   = '0;
            end
            default: begin
                cnt_next = cnt_inc;
                if (cnt_inc >= CNT_W'(MAX_HEADER_BYTES)) begin
                    result.kind = KIND_ILL;
                    cnt_next    = '0;
                    acc_next    = '0;
                    over_next   = 1'b0;
                end else if (is_digit) begin
                    acc_next  = acc_mac[LEN_W-1:0];
                    over_next = over_reg | (|acc_mac[LEN_W+3:LEN_W]);
                end else if (rx_byte == CHAR_COLON) begin
                    if (over_reg || (acc_reg > capacity)) begin
                        result.kind = KIND_BIG;
                        cnt_next    = '0;
                        acc_next    = '0;
                        over_next   = 1'b0;
                    end else begin
                        cnt_next   = '0;
                        rem_next   = acc_reg;
                        phase_next = (acc_reg == '0) ? PH_TRAILER : PH_PAYLOAD;
                    end
                end else begin
                    result.kind = KIND_ILL;
                    cnt_next    = '0;
                    acc_next    = '0;
                    over_next   = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            over_reg  <= 1'b0;
            rem_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            over_reg  <= over_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

/* src/netstring_deframer.sv */
// Netstring deframer top level: input register, parser, result register.
//
// Deframes "<decimal length>:<payload>," from a byte stream, one byte per
// s_ beat, and gives exactly one m_ beat per input byte. m_tuser carries
// the beat kind: 0 header byte taken, 1 payload byte, 2 frame complete,
// 3 ill formed, 4 too large. Payload bytes come in order in m_tdata[7:0]
// with m_tlast on the final one; a complete frame reports its length in
// m_tdata[39:8]. Header bytes must be digits or the colon; the header byte
// that reaches MAX_HEADER_BYTES is ill formed. At the colon the length is
// checked against buffer_capacity (cfg_wr_data, reset 4096); the value in
// force at the colon applies. After a complete frame or any error the
// parser returns to the header phase. Throughput is one byte per cycle
// unless m_tready is low; a byte passes the input register, then the parse
// step into the result register. Both stages are registered: the block
// takes bytes while a result waits; stalls need both full and m_tready low.
module netstring_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [ndf_pkg::CAP_W-1:0]   cfg_wr_data,
    // byte stream in
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // deframed beats out
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // [7:0] payload_byte, [39:8] frame_length
    output logic                        m_tlast,   // payload_last
    output logic [2:0]                  m_tuser    // [2:0] kind
);
    import ndf_pkg::*;

    logic [CAP_W-1:0]   cap_reg;

    // input stage
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;

    // result stage
    logic               out_valid_reg;
    result_t            out_reg;

    result_t            parse_res;
    logic               out_free;
    logic               step;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;      // byte moves into result stage
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(CAP_RESET);
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    ndf_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .rx_byte  (in_byte_reg),
        .capacity (cap_reg),
        .result   (parse_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= parse_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_length, out_reg.payload_byte};
    assign m_tlast  = out_reg.payload_last;
    assign m_tuser  = out_reg.kind;

`ifndef SYNTHESIS
    // last mark only rides on payload beats
    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD)
        else $error("tlast on a non-payload beat");

    // frame length is reported only on a completed frame
    a_len_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_DONE) |-> m_tdata[39:8] == '0)
        else $error("frame length on a non-done beat");

    // input stalls only with both stages full and the sink stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    // a byte held in the input stage reaches the output next cycle once free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_free |=> m_tvalid)
        else $error("accepted byte did not reach the result stage");
`endif

endmodule
